@@ hw/rtl/spl_pkg.sv @@
package spl_pkg;

	localparam int DEF_LIST_DEPTH = 16;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_PRIO_WIDTH = 32;

	// fixed beat field widths
	localparam int OP_W    = 3;
	localparam int FIELD_W = 32;
	localparam int CNT_W   = 5;

	// input beat layout
	localparam int IN_OP_LSB   = 0;
	localparam int IN_VAL_LSB  = IN_OP_LSB + OP_W;
	localparam int IN_PRI_LSB  = IN_VAL_LSB + FIELD_W;
	localparam int IN_USED     = IN_PRI_LSB + FIELD_W;
	localparam int IN_TDATA_W  = ((IN_USED + 7) / 8) * 8;

	// output beat layout
	localparam int OUT_HV_LSB    = 0;
	localparam int OUT_HP_LSB    = OUT_HV_LSB + FIELD_W;
	localparam int OUT_LV_LSB    = OUT_HP_LSB + FIELD_W;
	localparam int OUT_LP_LSB    = OUT_LV_LSB + FIELD_W;
	localparam int OUT_CNT_LSB   = OUT_LP_LSB + FIELD_W;
	localparam int OUT_EMPTY_BIT = OUT_CNT_LSB + CNT_W;
	localparam int OUT_FOUND_BIT = OUT_EMPTY_BIT + 1;
	localparam int OUT_FP_LSB    = OUT_FOUND_BIT + 1;
	localparam int OUT_MC_LSB    = OUT_FP_LSB + FIELD_W;
	localparam int OUT_REF_BIT   = OUT_MC_LSB + CNT_W;
	localparam int OUT_USED      = OUT_REF_BIT + 1;
	localparam int OUT_TDATA_W   = ((OUT_USED + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT       = 3'd0,
		OP_REMOVE_HIGH  = 3'd1,
		OP_REMOVE_LOW   = 3'd2,
		OP_FIND         = 3'd3,
		OP_REMOVE_VALUE = 3'd4
	} op_t;

	// shared command to every cell
	typedef struct packed {
		logic ins;       // insert new entry at its sorted place
		logic rem_head;  // shift whole row toward the head
		logic rem_val;   // shift from first match onward
	} cell_ctrl_t;

endpackage

@@ hw/rtl/spl_cell.sv @@
module spl_cell #(
	parameter int DATA_WIDTH = spl_pkg::DEF_DATA_WIDTH,
	parameter int PRIO_WIDTH = spl_pkg::DEF_PRIO_WIDTH
) (
	input  logic                  clk,
	input  spl_pkg::cell_ctrl_t   ctrl,
	input  logic                  valid,
	input  logic [DATA_WIDTH-1:0] new_value,
	input  logic [PRIO_WIDTH-1:0] new_prio,
	input  logic [DATA_WIDTH-1:0] prev_value,
	input  logic [PRIO_WIDTH-1:0] prev_prio,
	input  logic [DATA_WIDTH-1:0] next_value,
	input  logic [PRIO_WIDTH-1:0] next_prio,
	input  logic                  ge_prev,
	output logic                  ge_out,
	input  logic                  seen_prev,
	output logic                  seen_out,
	output logic                  match,
	output logic [DATA_WIDTH-1:0] value,
	output logic [PRIO_WIDTH-1:0] prio
);

	logic [DATA_WIDTH-1:0] value_q;
	logic [PRIO_WIDTH-1:0] prio_q;
	logic                  ge_self;

	// ties keep arrival order: new entry goes after equal priorities
	assign ge_self  = valid && ($signed(prio_q) >= $signed(new_prio));
	assign match    = valid && (value_q == new_value);
	assign ge_out   = ge_self;
	assign seen_out = seen_prev | match;
	assign value    = value_q;
	assign prio     = prio_q;

	// insert and the removals never come together; idle cycles hold
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!ge_self) begin
				if (ge_prev) begin
					value_q <= new_value;
					prio_q  <= new_prio;
				end else begin
					value_q <= prev_value;
					prio_q  <= prev_prio;
				end
			end
		end else if (ctrl.rem_head || (ctrl.rem_val && seen_out)) begin
			value_q <= next_value;
			prio_q  <= next_prio;
		end
	end

endmodule

@@ hw/rtl/sorted_priority_list.sv @@
// Channel  Dir  Fields in tdata (lowest bit first)
// -------  ---  ---------------------------------------------------------------
// s_*      in   operation, item_value, item_priority
// m_*      out  highest_value, highest_priority, lowest_value, lowest_priority,
//               entry_count, list_empty, found, found_priority, match_count,
//               insert_refused
//
// One beat per cycle while the master side keeps up. A beat updates the cell
// row at its accept edge and is parked; its result goes into the output
// register once the output is free. Reset clears the entry count and the
// handshake flags; cell contents stay unknown and no clearing pass runs.
// While the output waits, one more beat is taken and parked; then s_tready
// drops until m_tready.
module sorted_priority_list #(
	parameter int LIST_DEPTH = spl_pkg::DEF_LIST_DEPTH,
	parameter int DATA_WIDTH = spl_pkg::DEF_DATA_WIDTH,
	parameter int PRIO_WIDTH = spl_pkg::DEF_PRIO_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// operation, item_value, item_priority, zero pad
	input  logic [spl_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// highest_value, highest_priority, lowest_value, lowest_priority,
	// entry_count, list_empty, found, found_priority, match_count,
	// insert_refused, zero pad
	output logic [spl_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int CW = $clog2(LIST_DEPTH + 1);

	// input beat fields
	logic [spl_pkg::OP_W-1:0]    in_op;
	logic [spl_pkg::FIELD_W-1:0] in_val_raw;
	logic [spl_pkg::FIELD_W-1:0] in_pri_raw;
	logic [63:0]                 in_val_w;
	logic [63:0]                 in_pri_w;
	logic [DATA_WIDTH-1:0]       in_val;
	logic [PRIO_WIDTH-1:0]       in_pri;

	assign in_op      = s_tdata[spl_pkg::IN_OP_LSB +: spl_pkg::OP_W];
	assign in_val_raw = s_tdata[spl_pkg::IN_VAL_LSB +: spl_pkg::FIELD_W];
	assign in_pri_raw = s_tdata[spl_pkg::IN_PRI_LSB +: spl_pkg::FIELD_W];
	assign in_val_w   = 64'(in_val_raw);
	assign in_pri_w   = 64'(in_pri_raw);
	assign in_val     = in_val_w[DATA_WIDTH-1:0];
	assign in_pri     = in_pri_w[PRIO_WIDTH-1:0];

	// control state
	logic [CW-1:0] occ_q;
	logic          pend_s1_q;
	logic          out_valid_q;

	logic accept;
	logic out_free;
	logic full;
	logic nonempty;
	logic is_ins;
	logic is_search;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !pend_s1_q || out_free;
	assign accept   = s_tvalid && s_tready;
	assign full     = (occ_q == CW'(LIST_DEPTH));
	assign nonempty = (occ_q != '0);
	assign is_ins   = (in_op == spl_pkg::OP_INSERT);
	assign is_search = (in_op == spl_pkg::OP_FIND) || (in_op == spl_pkg::OP_REMOVE_VALUE);

	spl_pkg::cell_ctrl_t ctrl;

	assign ctrl.ins      = accept && is_ins && !full;
	assign ctrl.rem_head = accept && (in_op == spl_pkg::OP_REMOVE_HIGH) && nonempty;
	assign ctrl.rem_val  = accept && (in_op == spl_pkg::OP_REMOVE_VALUE);

	// cell row
	logic [DATA_WIDTH-1:0] cell_val  [LIST_DEPTH];
	logic [PRIO_WIDTH-1:0] cell_pri  [LIST_DEPTH];
	logic [DATA_WIDTH-1:0] prev_val  [LIST_DEPTH];
	logic [PRIO_WIDTH-1:0] prev_pri  [LIST_DEPTH];
	logic [DATA_WIDTH-1:0] next_val  [LIST_DEPTH];
	logic [PRIO_WIDTH-1:0] next_pri  [LIST_DEPTH];
	logic                  ge_chain  [LIST_DEPTH+1];
	logic                  seen_chain[LIST_DEPTH+1];
	logic [LIST_DEPTH-1:0] match_vec;

	assign ge_chain[0]   = 1'b1;
	assign seen_chain[0] = 1'b0;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_val[i] = in_val;
			assign prev_pri[i] = in_pri;
		end else begin : g_mid
			assign prev_val[i] = cell_val[i-1];
			assign prev_pri[i] = cell_pri[i-1];
		end
		if (i == LIST_DEPTH - 1) begin : g_last
			assign next_val[i] = cell_val[i];
			assign next_pri[i] = cell_pri[i];
		end else begin : g_inner
			assign next_val[i] = cell_val[i+1];
			assign next_pri[i] = cell_pri[i+1];
		end

		spl_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.PRIO_WIDTH (PRIO_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.valid      (CW'(i) < occ_q),
			.new_value  (in_val),
			.new_prio   (in_pri),
			.prev_value (prev_val[i]),
			.prev_prio  (prev_pri[i]),
			.next_value (next_val[i]),
			.next_prio  (next_pri[i]),
			.ge_prev    (ge_chain[i]),
			.ge_out     (ge_chain[i+1]),
			.seen_prev  (seen_chain[i]),
			.seen_out   (seen_chain[i+1]),
			.match      (match_vec[i]),
			.value      (cell_val[i]),
			.prio       (cell_pri[i])
		);
	end

	// search results, taken before any removal
	logic                  any_match;
	logic [PRIO_WIDTH-1:0] first_pri;
	logic [CW-1:0]         match_cnt;

	assign any_match = seen_chain[LIST_DEPTH];
	assign match_cnt = CW'($countones(match_vec));

	always_comb begin
		first_pri = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (match_vec[i] && !seen_chain[i]) begin
				first_pri = first_pri | cell_pri[i];
			end
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctrl.ins) begin
			occ_q <= occ_q + CW'(1);
		end else if (ctrl.rem_head || (ctrl.rem_val && any_match) ||
		             (accept && (in_op == spl_pkg::OP_REMOVE_LOW) && nonempty)) begin
			occ_q <= occ_q - CW'(1);
		end
	end

	// parked flags of the beat whose row update is done
	logic                  found_s1;
	logic [PRIO_WIDTH-1:0] fpri_s1;
	logic [CW-1:0]         mcnt_s1;
	logic                  refused_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1_q <= 1'b0;
		end else if (accept) begin
			pend_s1_q <= 1'b1;
		end else if (out_free) begin
			pend_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_s1   <= is_search && any_match;
			fpri_s1    <= is_search ? first_pri : '0;
			mcnt_s1    <= is_search ? match_cnt : '0;
			refused_s1 <= is_ins && full;
		end
	end

	// head and tail of the updated row
	logic [DATA_WIDTH-1:0] tail_val;
	logic [PRIO_WIDTH-1:0] tail_pri;
	logic [CW-1:0]         tail_idx;

	assign tail_idx = occ_q - CW'(1);

	always_comb begin
		tail_val = '0;
		tail_pri = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (nonempty && (CW'(i) == tail_idx)) begin
				tail_val = tail_val | cell_val[i];
				tail_pri = tail_pri | cell_pri[i];
			end
		end
	end

	logic [63:0] hv_w, hp_w, lv_w, lp_w, fp_w;
	logic [31:0] cnt_w, mc_w;

	assign hv_w  = nonempty ? 64'(cell_val[0]) : '0;
	assign hp_w  = nonempty ? 64'(cell_pri[0]) : '0;
	assign lv_w  = 64'(tail_val);
	assign lp_w  = 64'(tail_pri);
	assign fp_w  = 64'(fpri_s1);
	assign cnt_w = 32'(occ_q);
	assign mc_w  = 32'(mcnt_s1);

	logic [spl_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic [spl_pkg::OUT_TDATA_W-1:0] out_data_d;

	always_comb begin
		out_data_d = '0;
		out_data_d[spl_pkg::OUT_HV_LSB +: spl_pkg::FIELD_W]  = hv_w[spl_pkg::FIELD_W-1:0];
		out_data_d[spl_pkg::OUT_HP_LSB +: spl_pkg::FIELD_W]  = hp_w[spl_pkg::FIELD_W-1:0];
		out_data_d[spl_pkg::OUT_LV_LSB +: spl_pkg::FIELD_W]  = lv_w[spl_pkg::FIELD_W-1:0];
		out_data_d[spl_pkg::OUT_LP_LSB +: spl_pkg::FIELD_W]  = lp_w[spl_pkg::FIELD_W-1:0];
		out_data_d[spl_pkg::OUT_CNT_LSB +: spl_pkg::CNT_W]   = cnt_w[spl_pkg::CNT_W-1:0];
		out_data_d[spl_pkg::OUT_EMPTY_BIT]                   = !nonempty;
		out_data_d[spl_pkg::OUT_FOUND_BIT]                   = found_s1;
		out_data_d[spl_pkg::OUT_FP_LSB +: spl_pkg::FIELD_W]  = fp_w[spl_pkg::FIELD_W-1:0];
		out_data_d[spl_pkg::OUT_MC_LSB +: spl_pkg::CNT_W]    = mc_w[spl_pkg::CNT_W-1:0];
		out_data_d[spl_pkg::OUT_REF_BIT]                     = refused_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pend_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && pend_s1_q) begin
			out_data_q <= out_data_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(LIST_DEPTH))
		else $error("entry count beyond list depth");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_ins && full |=> occ_q == $past(occ_q))
		else $error("refused insert changed the entry count");

	a_parked_kept: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1_q && out_valid_q && !m_tready |=> pend_s1_q && out_valid_q)
		else $error("parked beat lost while output stalled");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1_q && !out_free |-> !s_tready)
		else $error("input taken with parked beat and stalled output");

endmodule
